[sv/sorted_list_insert_macros.svh]
// Assertion macros for the sorted list insert block.
`ifndef SORTED_LIST_INSERT_MACROS_SVH
`define SORTED_LIST_INSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`define SLI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SLI_ASSERT_NEVER(label, clk, rst, cond)
`define SLI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/sli_pkg.sv]
// Package: widths, op codes and sequencer states for the sorted list insert block.
package sli_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int CAPACITY_DEF = 16;
  localparam int RESULT_LIMIT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_READOUT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INS_RD  = 6'b000010,
    ST_INS_CMP = 6'b000100,
    ST_RD_REQ  = 6'b001000,
    ST_RD_LOAD = 6'b010000,
    ST_RD_WAIT = 6'b100000
  } state_t;

endpackage

[sv/sli_store.sv]
// Value store: single write port, one registered read port.
module sli_store #(
  parameter int DEPTH = sli_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic signed [sli_pkg::DATA_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic signed [sli_pkg::DATA_W-1:0] rd_data
);
  import sli_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/sorted_list_insert.sv]
// Sorted list insert: ordered store of signed values with insert, readout and clear.
// Insert walks the list from the top with one shared signed comparator, one memory read per step,
// shifting each stored value greater than the new one up by a slot. Readout fetches the next
// result only after the output has taken the last one. Synchronous reset empties the list and
// clears the overflow flag.
`include "sorted_list_insert_macros.svh"
module sorted_list_insert #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sli_pkg::DATA_W-1:0]    s_axis_tdata,  // value
  input  logic [sli_pkg::OP_W-1:0]      s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sli_pkg::DATA_W-1:0]    m_axis_tdata,  // entry
  output logic                          m_axis_tlast,
  output logic [1:0]                    m_axis_tuser   // empty_res, overflow
);
  import sli_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic overflow_seen, overflow_seen_next;
  logic signed [DATA_W-1:0] ins_val;

  logic out_valid, out_valid_next;
  logic signed [DATA_W-1:0] out_entry;
  logic out_last, out_empty, out_ovf;
  logic load_out, load_empty;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data, rd_data;

  logic in_xfer, out_xfer, shift_up, rd_last;
  logic [CNT_W-1:0] rd_n;
  op_t op;

  sli_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign op            = op_t'(s_axis_tuser);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign shift_up      = (rd_data > ins_val);
  assign rd_n          = (CAPACITY > RESULT_LIMIT && count > CNT_W'(RESULT_LIMIT)) ?
                         CNT_W'(RESULT_LIMIT) : count;
  assign rd_last       = (CNT_W'(idx) + 1'b1 == rd_n);

  always_comb begin
    state_next         = state;
    count_next         = count;
    idx_next           = idx;
    overflow_seen_next = overflow_seen;
    out_valid_next     = out_valid;
    load_out           = 1'b0;
    load_empty         = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = idx;
    wr_data            = ins_val;
    rd_addr            = idx;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (op)
            OP_INSERT: begin
              if (count >= CNT_W'(CAPACITY)) begin
                overflow_seen_next = 1'b1;
              end else begin
                idx_next   = count[IDX_W-1:0];
                state_next = ST_INS_RD;
              end
            end
            OP_READOUT: begin
              idx_next   = '0;
              state_next = ST_RD_REQ;
            end
            OP_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      ST_INS_RD: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
          state_next = ST_IDLE;
        end else begin
          rd_addr    = idx - 1'b1;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (shift_up) begin
          wr_data    = rd_data;
          idx_next   = idx - 1'b1;
          state_next = ST_INS_RD;
        end else begin
          count_next = count + 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD_REQ: state_next = ST_RD_LOAD;
      ST_RD_LOAD: begin
        load_out       = 1'b1;
        load_empty     = (count == '0);
        out_valid_next = 1'b1;
        state_next     = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (out_xfer) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_RD_REQ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      idx           <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      idx           <= idx_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ins_val <= $signed(s_axis_tdata);
    end
    if (load_out) begin
      out_entry <= load_empty ? '0 : rd_data;
      out_last  <= load_empty ? 1'b1 : rd_last;
      out_empty <= load_empty;
      out_ovf   <= overflow_seen;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_entry;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_ovf, out_empty};

  `SLI_ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(CAPACITY))
  `SLI_ASSERT_IMPLIES(a_write_in_insert, clk, rst, wr_en,
    state == ST_INS_RD || state == ST_INS_CMP)
  `SLI_ASSERT_NEXT(a_full_sets_ovf, clk, rst,
    in_xfer && op == OP_INSERT && count == CNT_W'(CAPACITY), overflow_seen)
  `SLI_ASSERT_NEVER(a_ovf_sticky, clk, rst, $fell(overflow_seen))
  `SLI_ASSERT_IMPLIES(a_out_only_readout, clk, rst, m_axis_tvalid, state == ST_RD_WAIT)

endmodule

[test/sorted_list_insert_test.sv]
// Testbench for sorted_list_insert: directed table plus random insert/readout/clear traffic.
`timescale 1ns / 100ps

module sorted_list_insert_test;
  import sli_pkg::*;

  localparam int LIST_CAP     = CAPACITY_DEF;
  localparam int RAND_ITEMS   = 225;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    logic [DATA_W-1:0] entry;
    logic              last;
    logic              empty_res;
    logic              overflow;
  } list_result_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] val;
    logic              typed_in;
    list_result_t      res;
  } stim_row_t;

  localparam list_result_t NO_RES      = '0;
  localparam list_result_t EMPTY_CLEAN = '{32'h0, 1'b1, 1'b1, 1'b0};

  // typed_in rows carry their readout result; the rest go through the predictor
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READOUT, 32'h0000_0000, 1'b1, EMPTY_CLEAN},
    '{OP_NONE,    32'hFFFF_FFFF, 1'b0, NO_RES},
    '{OP_READOUT, 32'hFFFF_FFFF, 1'b1, EMPTY_CLEAN},
    '{OP_INSERT,  32'h0000_0000, 1'b0, NO_RES},
    '{OP_INSERT,  32'h7FFF_FFFF, 1'b0, NO_RES},
    '{OP_INSERT,  32'h8000_0000, 1'b0, NO_RES},
    '{OP_INSERT,  32'hFFFF_FFFF, 1'b0, NO_RES},
    '{OP_INSERT,  32'h0000_0000, 1'b0, NO_RES},
    '{OP_INSERT,  32'h0000_0001, 1'b0, NO_RES},
    '{OP_INSERT,  32'hFFFF_FFFE, 1'b0, NO_RES},
    '{OP_READOUT, 32'h0000_0000, 1'b0, NO_RES},
    '{OP_NONE,    32'h1234_5678, 1'b0, NO_RES},
    '{OP_READOUT, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{OP_CLEAR,   32'hAAAA_AAAA, 1'b0, NO_RES},
    '{OP_READOUT, 32'h0000_0000, 1'b1, EMPTY_CLEAN},
    '{OP_INSERT,  32'h5555_5555, 1'b0, NO_RES},
    '{OP_READOUT, 32'h0000_0000, 1'b0, NO_RES},
    '{OP_CLEAR,   32'h0000_0000, 1'b0, NO_RES},
    '{OP_CLEAR,   32'hFFFF_FFFF, 1'b0, NO_RES},
    '{OP_READOUT, 32'h0000_0000, 1'b1, EMPTY_CLEAN},
    '{OP_INSERT,  32'h8000_0000, 1'b0, NO_RES},
    '{OP_INSERT,  32'h8000_0000, 1'b0, NO_RES},
    '{OP_READOUT, 32'h0000_0000, 1'b0, NO_RES}
  };

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;   // value
  logic [OP_W-1:0]   s_axis_tuser;   // op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;   // entry
  logic              m_axis_tlast;
  logic [1:0]        m_axis_tuser;   // empty_res, overflow

  // shadow copy of the list
  logic signed [DATA_W-1:0] shadow_vals [LIST_CAP];
  int                       shadow_len;
  logic                     shadow_ovf;

  list_result_t pending_readout_q [$];
  int           fail_count;
  int           items_sent;
  int           entries_seen;
  int           cycle_count;
  logic         quiet;

  sorted_list_insert u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readout results outstanding",
               cycle_count, pending_readout_q.size());
      $display("sorted_list_insert verification failed");
      $finish;
    end
  end

  // Apply one accepted item to the shadow list and queue the readout it produces.
  function automatic void apply_list_op(op_t op, logic [DATA_W-1:0] val);
    int pos;
    int n;
    list_result_t r;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= LIST_CAP) begin
          shadow_ovf = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_vals[pos] <= $signed(val))
            pos++;
          for (int i = shadow_len; i > pos; i--)
            shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[pos] = val;
          shadow_len++;
        end
      end
      OP_READOUT: begin
        if (shadow_len == 0) begin
          r = '{32'h0, 1'b1, 1'b1, shadow_ovf};
          pending_readout_q.push_back(r);
        end else begin
          n = (shadow_len > RESULT_LIMIT) ? RESULT_LIMIT : shadow_len;
          for (int i = 0; i < n; i++) begin
            r = '{shadow_vals[i], (i == n - 1), 1'b0, shadow_ovf};
            pending_readout_q.push_back(r);
          end
        end
      end
      OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(2);
      1: return 32'h8000_0000 + $urandom_range(2);
      2, 3: return $urandom_range(6) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Drive one item, idling at random first, and hold it until the transfer.
  task automatic send_item(op_t op, logic [DATA_W-1:0] val, logic typed_in,
                           list_result_t res);
    while (!quiet && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (typed_in)
      pending_readout_q.push_back(res);
    else
      apply_list_op(op, val);
    items_sent++;
  endtask

  task automatic send_op(op_t op, logic [DATA_W-1:0] val);
    send_item(op, val, 1'b0, NO_RES);
  endtask

  // Output side: random backpressure and result checking.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 38);
      if (m_axis_tvalid && m_axis_tready) begin
        entries_seen++;
        if (pending_readout_q.size() == 0) begin
          $error("unexpected result: entry %0d last %0b tuser %b",
                 $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
          fail_count++;
        end else begin
          want = pending_readout_q.pop_front();
          if (m_axis_tdata !== want.entry) begin
            $error("entry: expected %0d, got %0d", $signed(want.entry), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.empty_res) begin
            $error("empty_res: expected %0b, got %0b", want.empty_res, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tuser[1] !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tuser[1]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int n_ins;
    int rand_start;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_NONE;
    quiet         = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    entries_seen  = 0;
    cycle_count   = 0;
    shadow_len    = 0;
    shadow_ovf    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed_in,
                directed_rows[i].res);

    // random part: mostly clear / fill / read runs, some loose noise items
    rand_start = items_sent;
    n_ins = LIST_CAP + 2;
    send_op(OP_CLEAR, $urandom);
    while (items_sent - rand_start < RAND_ITEMS) begin
      quiet = (items_sent - rand_start >= 120) && (items_sent - rand_start < 175);
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(3) != 0)
          send_op(OP_CLEAR, $urandom);
        for (int k = 0; k < n_ins; k++) begin
          send_op(OP_INSERT, pick_value());
          if ($urandom_range(19) == 0)
            send_op(OP_READOUT, $urandom);
        end
        send_op(OP_READOUT, $urandom);
        if ($urandom_range(4) == 0)
          send_op(OP_READOUT, $urandom);
        n_ins = ($urandom_range(4) == 0) ? $urandom_range(LIST_CAP + 4, LIST_CAP - 2)
                                         : $urandom_range(LIST_CAP - 1);
      end else begin
        send_op(op_t'($urandom_range(3)), pick_value());
      end
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_readout_q.size() != 0) begin
      $error("%0d readout results never arrived", pending_readout_q.size());
      fail_count++;
    end

    $display("Ran %0d items (%0d from the table) and checked %0d readout results.",
             items_sent, N_DIRECTED, entries_seen);
    $display("Overflow flag reached: %0b, mismatches: %0d", shadow_ovf, fail_count);
    if (fail_count == 0)
      $display("sorted_list_insert verification clean");
    else
      $display("sorted_list_insert verification failed");
    $finish;
  end

endmodule
